/* hdl/assert_macros.svh */
// Assertion macros for the rotation matrix to quaternion block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* hdl/rmq_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int FIELD_W = 18;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W = 26;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int NUM_W = 20;
  localparam int QUO_W = 48;
  localparam logic signed [FIELD_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [FIELD_W-1:0] OUT_MIN = -18'sh20000;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;
  localparam axis_t AXIS_W = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               bad;
    axis_t              big;
    logic signed [NUM_W-1:0] na;
    logic signed [NUM_W-1:0] nb;
    logic signed [NUM_W-1:0] nc;
  } rmq_ctl_t;

  function automatic axis_t axis_next(input axis_t a);
    unique case (a)
      AXIS_X: axis_next = AXIS_Y;
      AXIS_Y: axis_next = AXIS_Z;
      default: axis_next = AXIS_X;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, fully pipelined.
// Channels: s_axis carries one matrix per transaction, m_axis one quaternion.
// tdata in: m00..m22, 18 bits each, m00 lowest, 162 bits padded to 168.
// tdata out: q_w, q_x, q_y, q_z, 18 bits each, q_w lowest, 72 bits in all;
// tuser out: bad_input.
// Throughput: one transaction per cycle while the receiver does not stall.
// Stages: a set-up register, 13 square-root stages, a term set-up register,
// 24 divider stages and one output register.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled receiver holds every stage and nothing is lost or repeated.
// Reset clears all valid bits; the block accepts a transaction in the
// first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [167:0] s_axis_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // q_w q_x q_y q_z
  output logic         m_axis_tuser   // bad_input
);
  import rmq_pkg::*;
  localparam int SQ_ST = ROOT_W / 2;
  localparam int DV_ST = QUO_W / 2;

  logic adv;
  logic signed [FIELD_W-1:0] m [9];
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  for (genvar g = 0; g < 9; g++) begin : g_unpack
    assign m[g] = s_axis_tdata[g*FIELD_W +: FIELD_W];
  end

  // set-up: pick path, radicand, numerators
  rmq_ctl_t ctl_next, ctl0;
  logic [RAD_W-1:0] rad_next, rad0;
  always_comb begin
    logic signed [FIELD_W+2:0] tr, rd, ii, jj, kk;
    axis_t i, j, k;
    logic signed [FIELD_W-1:0] d [3];
    d[0] = m[0]; d[1] = m[4]; d[2] = m[8];
    tr = 21'(d[0]) + 21'(d[1]) + 21'(d[2]);
    i = AXIS_X;
    if (d[1] > d[0]) i = AXIS_Y;
    if (d[2] > d[i]) i = AXIS_Z;
    j = axis_next(i);
    k = axis_next(j);
    ii = 21'(d[i]); jj = 21'(d[j]); kk = 21'(d[k]);
    ctl_next.valid = s_axis_tvalid;
    if (tr > 0) begin
      rd = tr + (21'(1) <<< FRAC_BITS);
      ctl_next.big = AXIS_W;
      ctl_next.na = NUM_W'(21'(m[7]) - 21'(m[5]));
      ctl_next.nb = NUM_W'(21'(m[2]) - 21'(m[6]));
      ctl_next.nc = NUM_W'(21'(m[3]) - 21'(m[1]));
    end else begin
      rd = ii - (jj + kk) + (21'(1) <<< FRAC_BITS);
      ctl_next.big = i;
      ctl_next.na = NUM_W'(21'(m[4'(3 * k + j)]) - 21'(m[4'(3 * j + k)]));
      ctl_next.nb = NUM_W'(21'(m[4'(3 * j + i)]) + 21'(m[4'(3 * i + j)]));
      ctl_next.nc = NUM_W'(21'(m[4'(3 * k + i)]) + 21'(m[4'(3 * i + k)]));
    end
    ctl_next.bad = (rd <= 0);
    rad_next = ctl_next.bad ? '0 : (RAD_W'(unsigned'(rd)) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else if (adv) begin
      ctl0 <= ctl_next;
      rad0 <= rad_next;
    end
  end

  // square root pipeline
  rmq_ctl_t sc [SQ_ST+1];
  logic [RAD_W-1:0]  sr [SQ_ST+1];
  logic [RAD_W-1:0]  srem [SQ_ST+1];
  logic [ROOT_W-1:0] sq [SQ_ST+1];
  assign sc[0] = ctl0;
  assign sr[0] = rad0;
  assign srem[0] = '0;
  assign sq[0] = '0;
  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    logic [RAD_W-1:0]  rem_c;
    logic [ROOT_W-1:0] root_c;
    rmq_sqrt_stage #(.STEP(g)) u_st (
      .rem_in(srem[g]), .root_in(sq[g]), .rad(sr[g]),
      .rem_out(rem_c), .root_out(root_c));
    always_ff @(posedge clk) begin
      if (rst) begin
        sc[g+1].valid <= 1'b0;
      end else if (adv) begin
        sc[g+1] <= sc[g];
        sr[g+1] <= sr[g];
        srem[g+1] <= rem_c;
        sq[g+1] <= root_c;
      end
    end
  end

  // term set-up: signs, magnitudes with rounding offset
  rmq_ctl_t tc;
  logic [ROOT_W-1:0] ts;
  logic [2:0] tneg;
  logic [QUO_W-1:0] tnum [3];
  always_ff @(posedge clk) begin
    logic signed [NUM_W-1:0] nn [3];
    logic [NUM_W-1:0] mg;
    nn[0] = sc[SQ_ST].na; nn[1] = sc[SQ_ST].nb; nn[2] = sc[SQ_ST].nc;
    if (rst) begin
      tc.valid <= 1'b0;
    end else if (adv) begin
      tc <= sc[SQ_ST];
      ts <= sq[SQ_ST];
      for (int t = 0; t < 3; t++) begin
        mg = nn[t][NUM_W-1] ? NUM_W'(-nn[t]) : NUM_W'(nn[t]);
        tneg[t] <= nn[t][NUM_W-1];
        tnum[t] <= (QUO_W'(mg) << FRAC_BITS) + QUO_W'(sq[SQ_ST]);
      end
    end
  end

  // divider pipelines
  rmq_ctl_t dc [DV_ST+1];
  logic [ROOT_W-1:0] ds [DV_ST+1];
  logic [2:0] dneg [DV_ST+1];
  logic [QUO_W-1:0] dn [3][DV_ST+1];
  logic [ROOT_W+1:0] drm [3][DV_ST+1];
  assign dc[0] = tc;
  assign ds[0] = ts;
  assign dneg[0] = tneg;
  for (genvar t = 0; t < 3; t++) begin : g_lane
    assign dn[t][0] = tnum[t];
    assign drm[t][0] = '0;
  end
  for (genvar g = 0; g < DV_ST; g++) begin : g_div
    logic [QUO_W-1:0] n_c [3];
    logic [ROOT_W+1:0] r_c [3];
    for (genvar t = 0; t < 3; t++) begin : g_l
      rmq_div_stage u_dv (
        .num_in(dn[t][g]), .rem_in(drm[t][g]), .den({ds[g], 1'b0}),
        .num_out(n_c[t]), .rem_out(r_c[t]));
      always_ff @(posedge clk) begin
        if (!rst && adv) begin
          dn[t][g+1] <= n_c[t];
          drm[t][g+1] <= r_c[t];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dc[g+1].valid <= 1'b0;
      end else if (adv) begin
        dc[g+1] <= dc[g];
        ds[g+1] <= ds[g];
        dneg[g+1] <= dneg[g];
      end
    end
  end

  // output: route, saturate
  function automatic logic signed [FIELD_W-1:0] sat(input logic [QUO_W-1:0] mg,
                                                    input logic neg);
    logic signed [QUO_W:0] v;
    v = neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
    if (v > (QUO_W+1)'(OUT_MAX)) sat = OUT_MAX;
    else if (v < (QUO_W+1)'(OUT_MIN)) sat = OUT_MIN;
    else sat = FIELD_W'(v);
  endfunction

  logic signed [FIELD_W-1:0] qv [4];
  always_comb begin
    logic signed [FIELD_W-1:0] a, b, c, h;
    axis_t i, j, k;
    a = sat(dn[0][DV_ST], dneg[DV_ST][0]);
    b = sat(dn[1][DV_ST], dneg[DV_ST][1]);
    c = sat(dn[2][DV_ST], dneg[DV_ST][2]);
    h = sat(QUO_W'(ds[DV_ST] >> 1), 1'b0);
    i = dc[DV_ST].big;
    j = axis_next(i);
    k = axis_next(j);
    for (int t = 0; t < 4; t++) qv[t] = '0;
    if (dc[DV_ST].bad) begin
      for (int t = 0; t < 4; t++) qv[t] = '0;
    end else if (i == AXIS_W) begin
      qv[0] = h; qv[1] = a; qv[2] = b; qv[3] = c;
    end else begin
      qv[0] = a;
      qv[i + 2'd1] = h;
      qv[j + 2'd1] = b;
      qv[k + 2'd1] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dc[DV_ST].valid;
      m_axis_tdata <= {qv[3], qv[2], qv[1], qv[0]};
      m_axis_tuser <= dc[DV_ST].bad;
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPLIES(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `ASSERT_IMPLIES(a_badzero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 72'd0)
endmodule
`default_nettype wire

/* hdl/rmq_sqrt_stage.sv */
// One restoring step pair of the pipelined integer square root.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_stage #(
  parameter int STEP = 0
) (
  input  wire  [rmq_pkg::RAD_W-1:0]  rem_in,
  input  wire  [rmq_pkg::ROOT_W-1:0] root_in,
  input  wire  [rmq_pkg::RAD_W-1:0]  rad,
  output logic [rmq_pkg::RAD_W-1:0]  rem_out,
  output logic [rmq_pkg::ROOT_W-1:0] root_out
);
  import rmq_pkg::*;
  localparam int B0 = ROOT_W - 1 - 2 * STEP;

  logic [RAD_W+1:0]  r1, t1, r2, t2;
  logic [ROOT_W-1:0] q1, q2;

  always_comb begin
    r1 = {rem_in, rad[2*B0+1 -: 2]};
    t1 = {2'b00, RAD_W'(root_in) << 2} | (RAD_W+2)'(1);
    if (r1 >= t1) begin
      r1 = r1 - t1;
      q1 = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      q1 = {root_in[ROOT_W-2:0], 1'b0};
    end
    r2 = {r1[RAD_W-1:0], rad[2*B0-1 -: 2]};
    t2 = {2'b00, RAD_W'(q1) << 2} | (RAD_W+2)'(1);
    if (r2 >= t2) begin
      r2 = r2 - t2;
      q2 = {q1[ROOT_W-2:0], 1'b1};
    end else begin
      q2 = {q1[ROOT_W-2:0], 1'b0};
    end
    rem_out = r2[RAD_W-1:0];
    root_out = q2;
  end
endmodule
`default_nettype wire

/* hdl/rmq_div_stage.sv */
// One two-bit step of the pipelined restoring divider for the quotient terms.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_stage (
  input  wire  [rmq_pkg::QUO_W-1:0]   num_in,
  input  wire  [rmq_pkg::ROOT_W+1:0]  rem_in,
  input  wire  [rmq_pkg::ROOT_W:0]    den,
  output logic [rmq_pkg::QUO_W-1:0]   num_out,
  output logic [rmq_pkg::ROOT_W+1:0]  rem_out
);
  import rmq_pkg::*;
  logic [ROOT_W+2:0] a, b;
  logic [QUO_W-1:0]  n;

  always_comb begin
    n = num_in;
    a = {rem_in, n[QUO_W-1]};
    n = {n[QUO_W-2:0], 1'b0};
    if (a >= {2'b00, den}) begin
      a = a - {2'b00, den};
      n[0] = 1'b1;
    end
    b = {a[ROOT_W+1:0], n[QUO_W-1]};
    n = {n[QUO_W-2:0], 1'b0};
    if (b >= {2'b00, den}) begin
      b = b - {2'b00, den};
      n[0] = 1'b1;
    end
    num_out = n;
    rem_out = b[ROOT_W+1:0];
  end
endmodule
`default_nettype wire
